@@ rtl/core/clbb_pkg.sv @@
// Shared types and constants for the cluster light binning block.
// No dependencies.
package clbb_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned WordW = 32;
    localparam int unsigned CntW = 7;
    localparam int unsigned StatW = 16;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_TEST  = 2'd1,
        OP_FRAME = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_EMIT = 2'd2
    } t_state;

    localparam logic CFG_ACTIVE = 1'b0;
    localparam logic CFG_LIMIT  = 1'b1;

    typedef struct packed {
        logic signed [CoordW-1:0] lo_x;
        logic signed [CoordW-1:0] lo_y;
        logic signed [CoordW-1:0] lo_z;
        logic signed [CoordW-1:0] hi_x;
        logic signed [CoordW-1:0] hi_y;
        logic signed [CoordW-1:0] hi_z;
        logic                     on;
    } t_box;

    typedef struct packed {
        logic signed [CoordW-1:0] cx;
        logic signed [CoordW-1:0] cy;
        logic signed [CoordW-1:0] cz;
        logic signed [CoordW-1:0] rad;
    } t_light;

endpackage

@@ rtl/core/cluster_light_bitmask_binning.sv @@
// Cluster light binning top level: request handshake, light cell chain, output words.
// Depends on clbb_pkg and clbb_cell.
// The occupancy words of a test request are valid once its box has passed the light cell
// chain, then one word per cycle while i_ready is high; results stay until
// taken. A new test request is taken only after the last word has been taken.
// Loads and frame starts are taken in the idle state. One request is in flight at a time.
// Synchronous active-low reset clears control, statistics and the active count, and sets the limit to 32.
module cluster_light_bitmask_binning #(
    parameter int unsigned MAX_LIGHTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_opcode,
    input  logic [5:0]          i_light_slot,
    input  logic signed [31:0]  i_a_x,
    input  logic signed [31:0]  i_a_y,
    input  logic signed [31:0]  i_a_z,
    input  logic signed [31:0]  i_b_x,
    input  logic signed [31:0]  i_b_y,
    input  logic signed [31:0]  i_b_z,
    input  logic signed [31:0]  i_sphere_radius,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [6:0]          i_cfg_data,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_word_index,
    output logic [31:0]         o_occupancy_word,
    output logic [1:0]          o_summary_bits,
    output logic [6:0]          o_lights_in_cluster,
    output logic                o_over_limit,
    output logic                o_last,
    output logic [6:0]          o_visible_lights,
    output logic [15:0]         o_nonempty_clusters,
    output logic [15:0]         o_overflow_clusters,
    output logic [6:0]          o_peak_lights
);
    import clbb_pkg::*;

    localparam int unsigned Words = (MAX_LIGHTS + 31) / 32;
    localparam int unsigned WIdxW = (Words > 1) ? $clog2(Words) : 1;
    localparam int unsigned LIdxW = $clog2(MAX_LIGHTS);
    localparam int unsigned NW = $clog2(MAX_LIGHTS + 1);
    localparam int unsigned CycW = $clog2(MAX_LIGHTS + 8);
    localparam int unsigned Lat = MAX_LIGHTS + 2;
    localparam int unsigned NzW = (Words > 2) ? Words : 2;

    t_state r_state, n_state;
    logic [6:0] r_active, r_limit;
    logic [StatW-1:0] r_nonempty, r_overflow;
    logic [CntW-1:0] r_peak;
    logic [CycW-1:0] r_cyc;
    logic [WIdxW-1:0] r_widx;
    logic [Words*32-1:0] r_bits;
    logic [NW-1:0] r_count, r_visible;
    logic [NW-1:0] r_n;

    t_box   box_chain [MAX_LIGHTS+1];
    logic   hit [MAX_LIGHTS];
    logic   vis [MAX_LIGHTS];
    t_light ld_light;

    logic acc;
    assign acc = i_valid && o_ready;
    assign o_ready = (r_state == ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign ld_light = '{cx: i_a_x, cy: i_a_y, cz: i_a_z, rad: i_sphere_radius};

    assign box_chain[0] = '{lo_x: i_a_x, lo_y: i_a_y, lo_z: i_a_z,
                            hi_x: i_b_x, hi_y: i_b_y, hi_z: i_b_z,
                            on: acc && (i_opcode == OP_TEST)};

    for (genvar g = 0; g < MAX_LIGHTS; g++) begin : g_cell
        clbb_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_load (acc && (i_opcode == OP_LOAD) &&
                     (32'(i_light_slot) == 32'(g))),
            .i_light(ld_light),
            .i_box  (box_chain[g]),
            .o_box  (box_chain[g+1]),
            .o_hit  (hit[g]),
            .o_vis  (vis[g])
        );
    end

    // Cell g holds its hit for the request during the cycle in which r_cyc is g+2.
    logic [NW-1:0] r_n_next;
    assign r_n_next = (32'(r_active) > 32'(MAX_LIGHTS)) ? NW'(MAX_LIGHTS) : NW'(r_active);

    logic [CntW-1:0] cnt7;
    logic over;
    assign cnt7 = (r_count > NW'(127)) ? 7'd127 : CntW'(r_count);
    assign over = 32'(r_count) > 32'(r_limit);

    logic [NzW-1:0] nz;
    always_comb begin
        nz = '0;
        for (int w = 0; w < Words; w++) begin
            nz[w] = |r_bits[w*32 +: 32];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (acc && i_opcode == OP_TEST) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_cyc == CycW'(Lat)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_ready && r_widx == WIdxW'(Words - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_active <= 7'd0;
            r_limit <= 7'd32;
            r_nonempty <= '0;
            r_overflow <= '0;
            r_peak <= '0;
            r_cyc <= '0;
            r_widx <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_ACTIVE) begin
                    r_active <= i_cfg_data;
                end else begin
                    r_limit <= i_cfg_data;
                end
            end
            if (acc && i_opcode == OP_FRAME) begin
                r_nonempty <= '0;
                r_overflow <= '0;
                r_peak <= '0;
            end
            if (r_state == ST_IDLE) begin
                r_cyc <= '0;
                r_widx <= '0;
            end else if (r_state == ST_RUN) begin
                r_cyc <= r_cyc + 1'b1;
                if (r_cyc == CycW'(Lat)) begin
                    if (over && r_overflow != '1) r_overflow <= r_overflow + 1'b1;
                    if (r_count != '0 && r_nonempty != '1) r_nonempty <= r_nonempty + 1'b1;
                    if (cnt7 > r_peak) r_peak <= cnt7;
                end
            end else if (r_state == ST_EMIT && i_ready) begin
                r_widx <= r_widx + 1'b1;
            end
        end
    end

    logic [CycW-1:0] ci;
    assign ci = r_cyc - CycW'(2);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_bits <= '0;
            r_count <= '0;
            r_visible <= '0;
            r_n <= r_n_next;
        end else if (r_state == ST_RUN && r_cyc >= CycW'(2) && r_cyc < CycW'(Lat)) begin
            if (32'(ci) < 32'(r_n)) begin
                if (hit[ci[LIdxW-1:0]]) begin
                    r_bits[ci[LIdxW-1:0]] <= 1'b1;
                    r_count <= r_count + 1'b1;
                end
                if (vis[ci[LIdxW-1:0]]) begin
                    r_visible <= r_visible + 1'b1;
                end
            end
        end
    end

    assign o_valid = (r_state == ST_EMIT);
    assign o_word_index = r_widx[0];
    assign o_occupancy_word = r_bits[r_widx*32 +: 32];
    assign o_summary_bits = nz[1:0];
    assign o_lights_in_cluster = cnt7;
    assign o_over_limit = over;
    assign o_last = (r_widx == WIdxW'(Words - 1));
    assign o_visible_lights = (r_visible > NW'(127)) ? 7'd127 : CntW'(r_visible);
    assign o_nonempty_clusters = r_nonempty;
    assign o_overflow_clusters = r_overflow;
    assign o_peak_lights = r_peak;

`ifndef ASSERT_OFF
    a_no_in_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready) else $error("accepted while busy");
    a_count_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(r_count) <= 32'(r_n))) else $error("count above active");
    a_last_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> !o_valid) else $error("extra word");
    a_chain_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !box_chain[MAX_LIGHTS].on) else $error("box left in chain");
`endif
endmodule

@@ rtl/core/clbb_cell.sv @@
// One light cell: stores one sphere and tests the box passing through it.
// Depends on clbb_pkg. The result is registered through the squares, partial sum and hit registers.
module clbb_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  clbb_pkg::t_light i_light,
    input  clbb_pkg::t_box i_box,
    output clbb_pkg::t_box o_box,
    output logic           o_hit,
    output logic           o_vis
);
    import clbb_pkg::*;

    t_light r_light;
    t_box   r_box;
    logic [63:0] r_sq_x, r_sq_y, r_sq_z, r_rr;
    logic        r_neg1, r_neg2;
    logic [64:0] r_sum_xy;
    logic [63:0] r_sq_z2, r_rr2;
    logic        r_hit;

    function automatic logic [32:0] axis_dist(input logic signed [31:0] p,
                                              input logic signed [31:0] lo,
                                              input logic signed [31:0] hi);
        logic signed [32:0] a;
        logic signed [32:0] b;
        logic signed [32:0] d;
        a = 33'(lo) - 33'(p);
        b = 33'(p) - 33'(hi);
        d = (a > b) ? a : b;
        return (d > 0) ? d : 33'd0;
    endfunction

    logic [32:0] dx, dy, dz;
    logic [63:0] px, py, pz, prr;
    logic [64:0] sum3;
    logic [63:0] sat_sum;
    assign dx = axis_dist(r_light.cx, i_box.lo_x, i_box.hi_x);
    assign dy = axis_dist(r_light.cy, i_box.lo_y, i_box.hi_y);
    assign dz = axis_dist(r_light.cz, i_box.lo_z, i_box.hi_z);
    assign px = dx[31:0] * dx[31:0];
    assign py = dy[31:0] * dy[31:0];
    assign pz = dz[31:0] * dz[31:0];
    assign prr = r_light.rad[30:0] * r_light.rad[30:0];
    assign sum3 = r_sum_xy + {1'b0, r_sq_z2};
    assign sat_sum = (sum3[64] || r_sum_xy[64]) ? {64{1'b1}} : sum3[63:0];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_light <= i_light;
        end
        r_sq_x   <= px | {64{dx[32]}};
        r_sq_y   <= py | {64{dy[32]}};
        r_sq_z   <= pz | {64{dz[32]}};
        r_rr     <= prr;
        r_neg1   <= r_light.rad[31];
        r_sum_xy <= {1'b0, r_sq_x} + {1'b0, r_sq_y};
        r_sq_z2  <= r_sq_z;
        r_rr2    <= r_rr;
        r_neg2   <= r_neg1;
        r_hit    <= !r_neg2 && (sat_sum <= r_rr2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box.on <= 1'b0;
        end else begin
            r_box.on <= i_box.on;
        end
        r_box.lo_x <= i_box.lo_x;
        r_box.lo_y <= i_box.lo_y;
        r_box.lo_z <= i_box.lo_z;
        r_box.hi_x <= i_box.hi_x;
        r_box.hi_y <= i_box.hi_y;
        r_box.hi_z <= i_box.hi_z;
    end

    assign o_box = r_box;
    assign o_hit = r_hit;
    assign o_vis = !r_light.rad[31];
endmodule
